[hw/rtl/segi_pkg.sv]
// ----------------------------------------------------------------------------
// segi_pkg
// Shared types of the segment intersection core.
// ----------------------------------------------------------------------------
package segi_pkg;

  typedef struct packed {
    logic hit;
    logic parallel;
  } segi_flags_t;

endpackage

[hw/rtl/segi_if.sv]
// ----------------------------------------------------------------------------
// segi_in_if / segi_out_if
// Valid/ready channels that carry segment pairs in and crossing results out.
// ----------------------------------------------------------------------------
interface segi_in_if #(
  parameter int CW = 16
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface segi_out_if #(
  parameter int CW = 16
);
  logic valid;
  logic ready;
  logic hit;
  logic is_parallel;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;

  modport source (output valid, hit, is_parallel, cross_x, cross_y, input ready);
  modport sink (input valid, hit, is_parallel, cross_x, cross_y, output ready);
endinterface

[hw/rtl/segment_intersection_core.sv]
// ----------------------------------------------------------------------------
// segment_intersection_core
// Strict crossing test of two 2D segments with the crossing point.
// ----------------------------------------------------------------------------
// The core accepts one segment pair per clock while nothing stalls and returns
// one result per transaction in order. The path runs through the difference
// and product registers, a two-entry queue, and COORD_WIDTH + 1 divider
// stages that each resolve one bit of the edge vector while scaling it by t.
// Both sides stall on their own.
module segment_intersection_core
  import segi_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  segi_in_if.sink     seg_i,
  segi_out_if.source  res_o
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = 2 * (CW + 1) + 1;
  localparam int QW = $bits(segi_flags_t) + 2 * CW + 2 * (CW + 1) + 2 * NW;

  logic                 f_valid, f_ready, b_valid, b_ready;
  segi_flags_t          f_flags, b_flags;
  logic signed [CW-1:0] f_ax, f_ay, b_ax, b_ay;
  logic signed [CW:0]   f_rx, f_ry, b_rx, b_ry;
  logic [NW-1:0]        f_num, f_den, b_num, b_den;
  logic [QW-1:0]        q_in, q_out;

  segi_front #(.CW(CW)) u_front (
    .clk_i, .rst_ni, .seg_i,
    .push_valid_o(f_valid), .push_ready_i(f_ready), .flags_o(f_flags),
    .ax_o(f_ax), .ay_o(f_ay), .rx_o(f_rx), .ry_o(f_ry),
    .num_mag_o(f_num), .den_mag_o(f_den)
  );

  assign q_in = {f_flags, f_ax, f_ay, f_rx, f_ry, f_num, f_den};
  assign {b_flags, b_ax, b_ay, b_rx, b_ry, b_num, b_den} = q_out;

  segi_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(q_in),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(q_out)
  );

  segi_back #(.CW(CW)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(b_valid), .pop_ready_o(b_ready), .flags_i(b_flags),
    .ax_i(b_ax), .ay_i(b_ay), .rx_i(b_rx), .ry_i(b_ry),
    .num_mag_i(b_num), .den_mag_i(b_den), .res_o
  );

endmodule

[hw/rtl/segi_front.sv]
// ----------------------------------------------------------------------------
// segi_front
// Forms the edge vectors and cross products and classifies each pair.
// ----------------------------------------------------------------------------
module segi_front
  import segi_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  segi_in_if.sink               seg_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output segi_flags_t           flags_o,
  output logic signed [CW-1:0]  ax_o,
  output logic signed [CW-1:0]  ay_o,
  output logic signed [CW:0]    rx_o,
  output logic signed [CW:0]    ry_o,
  output logic [2*CW+2:0]       num_mag_o,
  output logic [2*CW+2:0]       den_mag_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic adv1, adv2;
  logic v1_q, v2_q;
  logic signed [DW-1:0] rx_q, ry_q, sx_q, sy_q, qx_q, qy_q;
  logic signed [DW-1:0] rx2_q, ry2_q;
  logic signed [CW-1:0] ax_q, ay_q, ax2_q, ay2_q;
  logic signed [PW-1:0] p_rs_q, p_sr_q, p_ts_q, p_st_q, p_ur_q, p_ru_q;
  logic signed [NW-1:0] den, num_t, num_u;
  logic in_t, in_u;

  assign adv2 = ~v2_q | push_ready_i;
  assign adv1 = ~v1_q | adv2;
  assign seg_i.ready = adv1;
  assign push_valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= seg_i.valid;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      rx_q <= DW'(seg_i.first_end_x) - DW'(seg_i.first_start_x);
      ry_q <= DW'(seg_i.first_end_y) - DW'(seg_i.first_start_y);
      sx_q <= DW'(seg_i.second_end_x) - DW'(seg_i.second_start_x);
      sy_q <= DW'(seg_i.second_end_y) - DW'(seg_i.second_start_y);
      qx_q <= DW'(seg_i.second_start_x) - DW'(seg_i.first_start_x);
      qy_q <= DW'(seg_i.second_start_y) - DW'(seg_i.first_start_y);
      ax_q <= seg_i.first_start_x;
      ay_q <= seg_i.first_start_y;
    end
    if (adv2) begin
      p_rs_q <= rx_q * sy_q;
      p_sr_q <= ry_q * sx_q;
      p_ts_q <= qx_q * sy_q;
      p_st_q <= qy_q * sx_q;
      p_ur_q <= qx_q * ry_q;
      p_ru_q <= qy_q * rx_q;
      rx2_q  <= rx_q;
      ry2_q  <= ry_q;
      ax2_q  <= ax_q;
      ay2_q  <= ay_q;
    end
  end

  always_comb begin
    den   = NW'(p_rs_q) - NW'(p_sr_q);
    num_t = NW'(p_ts_q) - NW'(p_st_q);
    num_u = NW'(p_ur_q) - NW'(p_ru_q);
    if (!den[NW-1]) begin
      in_t = (num_t > 0) && (num_t < den);
      in_u = (num_u > 0) && (num_u < den);
    end else begin
      in_t = (num_t < 0) && (num_t > den);
      in_u = (num_u < 0) && (num_u > den);
    end
    flags_o.parallel = (den == '0);
    flags_o.hit      = ~flags_o.parallel & in_t & in_u;
    num_mag_o = num_t[NW-1] ? NW'(-num_t) : NW'(num_t);
    den_mag_o = den[NW-1] ? NW'(-den) : NW'(den);
  end

  assign ax_o = ax2_q;
  assign ay_o = ay2_q;
  assign rx_o = rx2_q;
  assign ry_o = ry2_q;

endmodule

[hw/rtl/segi_queue.sv]
// ----------------------------------------------------------------------------
// segi_queue
// Two-entry queue that decouples the classifier from the divider pipeline.
// ----------------------------------------------------------------------------
module segi_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

[hw/rtl/segi_back.sv]
// ----------------------------------------------------------------------------
// segi_back
// Bit-per-stage pipelined scaled divider that places the crossing point.
// ----------------------------------------------------------------------------
module segi_back
  import segi_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  segi_flags_t          flags_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW:0]   rx_i,
  input  logic signed [CW:0]   ry_i,
  input  logic [2*CW+2:0]      num_mag_i,
  input  logic [2*CW+2:0]      den_mag_i,
  segi_out_if.source           res_o
);

  localparam int DW = CW + 1;
  localparam int NW = 2 * DW + 1;

  typedef struct packed {
    logic [NW:0]   rem;
    logic [DW-1:0] quo;
  } lane_t;

  function automatic lane_t lane_step(lane_t cur, logic bit_in,
                                      logic [NW-1:0] num, logic [NW-1:0] den);
    lane_t      nxt;
    logic [NW:0] r;
    logic        c1, c2;
    r  = {cur.rem[NW-1:0], 1'b0};
    c1 = (r >= {1'b0, den});
    if (c1) r = r - {1'b0, den};
    c2 = 1'b0;
    if (bit_in) begin
      r  = r + {1'b0, num};
      c2 = (r >= {1'b0, den});
      if (c2) r = r - {1'b0, den};
    end
    nxt.rem = r;
    nxt.quo = {cur.quo[DW-2:0], 1'b0} + DW'(c1) + DW'(c2);
    return nxt;
  endfunction

  logic [DW:0]          adv;
  logic [DW-1:0]        v_q;
  lane_t                lx_q [DW];
  lane_t                ly_q [DW];
  segi_flags_t          fl_q [DW];
  logic signed [CW-1:0] ax_q [DW];
  logic signed [CW-1:0] ay_q [DW];
  logic                 sx_q [DW];
  logic                 sy_q [DW];
  logic [DW-1:0]        mx_q [DW];
  logic [DW-1:0]        my_q [DW];
  logic [NW-1:0]        num_q [DW];
  logic [NW-1:0]        den_q [DW];

  assign adv[DW] = res_o.ready;
  assign pop_ready_o = adv[0];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic                 v_in;
    lane_t                lx_in, ly_in;
    segi_flags_t          fl_in;
    logic signed [CW-1:0] ax_in, ay_in;
    logic                 sx_in, sy_in;
    logic [DW-1:0]        mx_in, my_in;
    logic [NW-1:0]        num_in, den_in;

    assign adv[k] = ~v_q[k] | adv[k+1];

    if (k == 0) begin : g_head
      assign v_in   = pop_valid_i;
      assign lx_in  = '0;
      assign ly_in  = '0;
      assign fl_in  = flags_i;
      assign ax_in  = ax_i;
      assign ay_in  = ay_i;
      assign sx_in  = rx_i[DW-1];
      assign sy_in  = ry_i[DW-1];
      assign mx_in  = rx_i[DW-1] ? DW'(-rx_i) : DW'(rx_i);
      assign my_in  = ry_i[DW-1] ? DW'(-ry_i) : DW'(ry_i);
      assign num_in = num_mag_i;
      assign den_in = den_mag_i;
    end else begin : g_body
      assign v_in   = v_q[k-1];
      assign lx_in  = lx_q[k-1];
      assign ly_in  = ly_q[k-1];
      assign fl_in  = fl_q[k-1];
      assign ax_in  = ax_q[k-1];
      assign ay_in  = ay_q[k-1];
      assign sx_in  = sx_q[k-1];
      assign sy_in  = sy_q[k-1];
      assign mx_in  = mx_q[k-1];
      assign my_in  = my_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        lx_q[k]  <= lane_step(lx_in, mx_in[DW-1-k], num_in, den_in);
        ly_q[k]  <= lane_step(ly_in, my_in[DW-1-k], num_in, den_in);
        fl_q[k]  <= fl_in;
        ax_q[k]  <= ax_in;
        ay_q[k]  <= ay_in;
        sx_q[k]  <= sx_in;
        sy_q[k]  <= sy_in;
        mx_q[k]  <= mx_in;
        my_q[k]  <= my_in;
        num_q[k] <= num_in;
        den_q[k] <= den_in;
      end
    end
  end

  logic [CW-1:0] px, py;

  always_comb begin
    px = sx_q[DW-1] ? CW'(ax_q[DW-1]) - CW'(lx_q[DW-1].quo)
                    : CW'(ax_q[DW-1]) + CW'(lx_q[DW-1].quo);
    py = sy_q[DW-1] ? CW'(ay_q[DW-1]) - CW'(ly_q[DW-1].quo)
                    : CW'(ay_q[DW-1]) + CW'(ly_q[DW-1].quo);
  end

  assign res_o.valid       = v_q[DW-1];
  assign res_o.hit         = fl_q[DW-1].hit;
  assign res_o.is_parallel = fl_q[DW-1].parallel;
  assign res_o.cross_x     = fl_q[DW-1].hit ? px : '0;
  assign res_o.cross_y     = fl_q[DW-1].hit ? py : '0;

endmodule
